// ===== rtl/gmf_pkg.sv =====
package gmf_pkg;

  // Scanner states
  typedef enum logic [2:0] {
    S_SEARCH = 3'd0,
    S_G      = 3'd1,
    S_GR     = 3'd2,
    S_GRI    = 3'd3,
    S_BODY   = 3'd4,
    S_S7     = 3'd5,
    S_S77    = 3'd6,
    S_S777   = 3'd7
  } scan_e;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_BAD_ED   = 3'd1,
    STAT_LEN_BIG  = 3'd2,
    STAT_NO_END   = 3'd3,
    STAT_TOO_LONG = 3'd4,
    STAT_BUF_LIM  = 3'd5
  } status_e;

  localparam logic [7:0]  CH_G  = 8'h47;
  localparam logic [7:0]  CH_R  = 8'h52;
  localparam logic [7:0]  CH_I  = 8'h49;
  localparam logic [7:0]  CH_B  = 8'h42;
  localparam logic [7:0]  CH_7  = 8'h37;

  localparam logic [7:0]  ED_MAX         = 8'd2;
  localparam logic [1:0]  ED_LONG_LEN    = 2'd2;
  localparam logic [31:0] LEN_END_SHORT  = 32'd8;
  localparam logic [31:0] LEN_END_LONG   = 32'd16;
  localparam logic [31:0] MAX_BYTES_RST  = 32'd1000000;

  // One queue entry: either a single result or the four-byte start marker
  typedef struct packed {
    logic          marker;
    logic [7:0]    data;
    logic          last;
    status_e       status;
    logic [1:0]    edition;
    logic [31:0]   length;
  } entry_t;

  function automatic logic [7:0] marker_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = CH_G;
      2'd1:    b = CH_R;
      2'd2:    b = CH_I;
      default: b = CH_B;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/grib_message_framer.sv =====
// Channel  | Handshake                 | Payload
// ---------+---------------------------+----------------------------------------
// input    | in_valid_i / in_stall_o   | data_byte_i
// output   | out_valid_o / out_stall_i | out_byte_o, first_byte_o, last_byte_o,
//          |                           | status_o, edition_o, message_length_o
// config   | cfg_valid_i / cfg_ready_o | max_message_bytes_i
//
// One byte is taken per cycle while in_stall_o is low; each result is registered
// in the result queue before output. A completed start marker yields four results,
// so the output side sets the pace: the two-entry queue fills and input stalls.
// in_stall_o comes from the queue fill count alone, with no path from out_stall_i.
// Reset returns the scanner to searching and sets the size limit to 1000000.
module grib_message_framer (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [7:0]   data_byte_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [7:0]   out_byte_o,
  output logic         first_byte_o,
  output logic         last_byte_o,
  output logic [2:0]   status_o,
  output logic [1:0]   edition_o,
  output logic [31:0]  message_length_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [31:0]  max_message_bytes_i
);
  import gmf_pkg::*;

  logic [31:0] max_bytes_q;
  logic        in_fire;
  logic        push;
  logic        full;
  entry_t      entry;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign in_fire     = in_valid_i && !full;

  // Hold the size limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= MAX_BYTES_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_bytes_q <= max_message_bytes_i;
    end
  end

  gmf_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .data_byte_i (data_byte_i),
    .max_bytes_i (max_bytes_q),
    .push_o      (push),
    .entry_o     (entry)
  );

  gmf_outq u_outq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .entry_i          (entry),
    .full_o           (full),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .first_byte_o     (first_byte_o),
    .last_byte_o      (last_byte_o),
    .status_o         (status_o),
    .edition_o        (edition_o),
    .message_length_o (message_length_o)
  );

endmodule

// ===== rtl/gmf_scan.sv =====
module gmf_scan (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_fire_i,
  input  logic [7:0]       data_byte_i,
  input  logic [31:0]      max_bytes_i,
  output logic             push_o,
  output gmf_pkg::entry_t  entry_o
);
  import gmf_pkg::*;

  scan_e       state_q, state_d;
  logic [31:0] count_q, count_d;
  logic [1:0]  ed_q, ed_d;
  logic        known_q, known_d;
  logic [23:0] short_q, short_d;
  logic [31:0] decl_q, decl_d;

  logic [31:0] count_inc;
  logic [31:0] len_end_cur;
  logic [31:0] len_end_n;
  logic [23:0] hold_n;
  logic [31:0] decl_a;
  logic [31:0] decl_n;
  logic [1:0]  ed_n;
  logic        known_n;
  logic        at8;
  logic        bad_ed;

  // Header field capture for the byte being taken
  always_comb begin
    count_inc   = count_q + 32'd1;
    len_end_cur = (ed_q == ED_LONG_LEN) ? LEN_END_LONG : LEN_END_SHORT;
    hold_n      = (count_inc >= 32'd5 && count_inc <= 32'd7) ?
                  {short_q[15:0], data_byte_i} : short_q;
    decl_a      = (known_q && ed_q == ED_LONG_LEN && count_inc >= 32'd13 &&
                   count_inc <= 32'd16) ? {decl_q[23:0], data_byte_i} : decl_q;
    at8         = (count_inc == 32'd8);
    bad_ed      = at8 && (data_byte_i > ED_MAX);
    ed_n        = at8 ? data_byte_i[1:0] : ed_q;
    known_n     = at8 ? 1'b1 : known_q;
    decl_n      = (at8 && data_byte_i < ED_MAX) ? {8'd0, short_q} : decl_a;
    len_end_n   = (ed_n == ED_LONG_LEN) ? LEN_END_LONG : LEN_END_SHORT;
  end

  // Next state and result entry
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ed_d    = ed_q;
    known_d = known_q;
    short_d = short_q;
    decl_d  = decl_q;
    push_o  = 1'b0;
    entry_o = '0;
    entry_o.status = STAT_OK;
    if (in_fire_i) begin
      unique case (state_q)
        S_SEARCH: state_d = (data_byte_i == CH_G) ? S_G : S_SEARCH;
        S_G:      state_d = (data_byte_i == CH_R) ? S_GR : S_SEARCH;
        S_GR:     state_d = (data_byte_i == CH_I) ? S_GRI : S_SEARCH;
        S_GRI: begin
          if (data_byte_i == CH_B) begin
            push_o         = 1'b1;
            entry_o.marker = 1'b1;
            count_d        = 32'd4;
            ed_d           = 2'd0;
            known_d        = 1'b0;
            short_d        = '0;
            decl_d         = '0;
            state_d        = S_BODY;
          end else begin
            state_d = S_SEARCH;
          end
        end
        S_BODY, S_S7, S_S77, S_S777: begin
          push_o = 1'b1;
          if (count_q >= max_bytes_i) begin
            // Drop the byte and abort on the buffer limit
            entry_o.last    = 1'b1;
            entry_o.status  = STAT_BUF_LIM;
            entry_o.edition = known_q ? ed_q : 2'd0;
            entry_o.length  = (known_q && count_q >= len_end_cur) ? decl_q : 32'd0;
            state_d         = S_SEARCH;
          end else begin
            count_d      = count_inc;
            entry_o.data = data_byte_i;
            if (state_q == S_BODY) begin
              short_d = hold_n;
              decl_d  = decl_n;
              if (bad_ed) begin
                known_d        = 1'b0;
                entry_o.last   = 1'b1;
                entry_o.status = STAT_BAD_ED;
                state_d        = S_SEARCH;
              end else begin
                ed_d    = ed_n;
                known_d = known_n;
                if (known_n && count_inc == len_end_n && decl_n > max_bytes_i) begin
                  entry_o.last    = 1'b1;
                  entry_o.status  = STAT_LEN_BIG;
                  entry_o.edition = ed_n;
                  entry_o.length  = decl_n;
                  state_d         = S_SEARCH;
                end else if (known_n && count_inc > len_end_n) begin
                  if (data_byte_i == CH_7) begin
                    state_d = S_S7;
                  end
                  if (count_inc > decl_n) begin
                    entry_o.last    = 1'b1;
                    entry_o.status  = STAT_NO_END;
                    entry_o.edition = ed_n;
                    entry_o.length  = decl_n;
                    state_d         = S_SEARCH;
                  end
                end
              end
            end else if (state_q == S_S7 || state_q == S_S77) begin
              // Advance through the end marker run
              if (data_byte_i == CH_7) begin
                state_d = (state_q == S_S7) ? S_S77 : S_S777;
              end else begin
                state_d = S_BODY;
              end
            end else begin
              if (data_byte_i == CH_7) begin
                if (count_inc >= decl_q) begin
                  entry_o.last    = 1'b1;
                  entry_o.status  = (count_inc > decl_q) ? STAT_TOO_LONG : STAT_OK;
                  entry_o.edition = ed_q;
                  entry_o.length  = decl_q;
                  state_d         = S_SEARCH;
                end
              end else begin
                state_d = S_BODY;
              end
            end
          end
        end
        default: state_d = S_SEARCH;
      endcase
    end
  end

  // Scanner registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SEARCH;
      count_q <= '0;
      ed_q    <= '0;
      known_q <= 1'b0;
      short_q <= '0;
      decl_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ed_q    <= ed_d;
      known_q <= known_d;
      short_q <= short_d;
      decl_q  <= decl_d;
    end
  end

endmodule

// ===== rtl/gmf_outq.sv =====
module gmf_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  gmf_pkg::entry_t  entry_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             first_byte_o,
  output logic             last_byte_o,
  output logic [2:0]       status_o,
  output logic [1:0]       edition_o,
  output logic [31:0]      message_length_o
);
  import gmf_pkg::*;

  entry_t      ent_q [2];
  logic        wr_q;
  logic        rd_q;
  logic [1:0]  cnt_q, cnt_d;
  logic [1:0]  burst_q;
  entry_t      head;
  logic        out_fire;
  logic        head_done;

  assign head        = ent_q[rd_q];
  assign out_valid_o = (cnt_q != 2'd0);
  assign full_o      = (cnt_q == 2'd2);
  assign out_fire    = out_valid_o && !out_stall_i;
  assign head_done   = out_fire && (!head.marker || burst_q == 2'd3);

  // Expand a marker entry into its four bytes
  always_comb begin
    if (head.marker) begin
      out_byte_o       = marker_byte(burst_q);
      first_byte_o     = (burst_q == 2'd0);
      last_byte_o      = 1'b0;
      status_o         = STAT_OK;
      edition_o        = 2'd0;
      message_length_o = 32'd0;
    end else begin
      out_byte_o       = head.data;
      first_byte_o     = 1'b0;
      last_byte_o      = head.last;
      status_o         = head.status;
      edition_o        = head.edition;
      message_length_o = head.length;
    end
  end

  assign cnt_d = cnt_q + {1'b0, push_i} - {1'b0, head_done};

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= entry_i;
    end
  end

  // Pointers, fill count and marker position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      cnt_q   <= '0;
      burst_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (head_done) begin
        rd_q    <= !rd_q;
        burst_q <= '0;
      end else if (out_fire) begin
        burst_q <= burst_q + 2'd1;
      end
    end
  end

endmodule

// ===== rtl/gmf_checker.sv =====
module gmf_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         out_valid_o,
  input  logic         out_stall_i,
  input  logic [7:0]   out_byte_o,
  input  logic         first_byte_o,
  input  logic         last_byte_o,
  input  logic [2:0]   status_o,
  input  logic [1:0]   edition_o,
  input  logic [31:0]  message_length_o
);
  import gmf_pkg::*;

  // A stalled item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  // A stalled item keeps its byte and last flag
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_byte_o) && $stable(last_byte_o))
    else $error("output item changed while stalled");

  // A message opens on a G that cannot also close it
  a_first_g: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && first_byte_o |-> out_byte_o == CH_G && !last_byte_o)
    else $error("first byte is not a plain G");

  // Status, edition and length are zero on all but the closing item
  a_mid_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_byte_o |->
      status_o == STAT_OK && edition_o == 2'd0 && message_length_o == 32'd0)
    else $error("trailer fields set on a middle item");

endmodule

bind grib_message_framer gmf_checker u_gmf_checker (.*);
